>>> hw/rtl/cwec_pkg.sv
// Shared types and constants for the circular window extreme colour block.
// No dependencies.
`default_nettype none
package cwec_pkg;
    localparam int DEF_MAX_WIDTH  = 640;
    localparam int DEF_MAX_HEIGHT = 480;
    localparam int DEF_MAX_RADIUS = 32;
    localparam int XW = 10;
    localparam int YW = 9;
    localparam int KSW = 12;
    localparam logic [XW-1:0] RST_WIDTH  = 10'd640;
    localparam logic [YW-1:0] RST_HEIGHT = 9'd480;
    localparam logic CFG_WIDTH  = 1'b0;
    localparam logic CFG_HEIGHT = 1'b1;
    localparam logic MODE_WRITE = 1'b0;

    typedef struct packed {
        logic          mode;
        logic [XW-1:0] x;
        logic [YW-1:0] y;
        logic [23:0]   pix;
        logic [KSW-1:0] ks;
    } cmd_t;
endpackage
`default_nettype wire

>>> hw/rtl/cwec_front.sv
// Front end: takes command words, holds a two-entry queue.
// Depends on cwec_pkg.
`default_nettype none
module cwec_front (
    input  wire logic           clk,
    input  wire logic           rst_n,
    input  wire logic           push,
    input  wire cwec_pkg::cmd_t push_cmd,
    output logic                full,
    input  wire logic           pop,
    output logic                avail,
    output cwec_pkg::cmd_t      head
);
    import cwec_pkg::*;
    cmd_t q_reg [2];
    logic [1:0] cnt_reg, cnt_next;
    logic rd_reg, wr_reg;

    assign full  = cnt_reg == 2'd2;
    assign avail = cnt_reg != 2'd0;
    assign head  = q_reg[rd_reg];

    always_comb
    begin
        cnt_next = cnt_reg + {1'b0, push} - {1'b0, pop};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg <= 2'd0;
            rd_reg  <= 1'b0;
            wr_reg  <= 1'b0;
        end
        else
        begin
            cnt_reg <= cnt_next;
            if (pop)
                rd_reg <= ~rd_reg;
            if (push)
                wr_reg <= ~wr_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
            q_reg[wr_reg] <= push_cmd;
    end
endmodule
`default_nettype wire

>>> hw/rtl/cwec_back.sv
// Back end: frame memory, radius, disc scan and extreme tracking.
// Depends on cwec_pkg.
`default_nettype none
module cwec_back #(
    parameter int MAX_WIDTH  = cwec_pkg::DEF_MAX_WIDTH,
    parameter int MAX_HEIGHT = cwec_pkg::DEF_MAX_HEIGHT,
    parameter int MAX_RADIUS = cwec_pkg::DEF_MAX_RADIUS
) (
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic                 avail,
    input  wire cwec_pkg::cmd_t       cmd,
    output logic                      pop,
    input  wire logic [cwec_pkg::XW-1:0] width_in,
    input  wire logic [cwec_pkg::YW-1:0] height_in,
    output logic                      done,
    output logic [23:0]               bright,
    output logic [23:0]               dark,
    output logic                      found
);
    import cwec_pkg::*;
    localparam int DEPTH = MAX_WIDTH * MAX_HEIGHT;
    localparam int AW = $clog2(DEPTH);
    localparam int RW = $clog2(MAX_RADIUS + 1);
    localparam int CW = 14;   // signed coordinate
    localparam int SQW = 2 * RW;

    localparam logic [3:0] S_IDLE = 4'd0, S_DIV = 4'd1, S_ROW = 4'd2, S_SQRT = 4'd3,
                           S_RND = 4'd4, S_PIX = 4'd5, S_DRAIN1 = 4'd6,
                           S_DRAIN2 = 4'd7, S_DONE = 4'd8, S_DRAIN3 = 4'd9;

    logic [23:0] mem [DEPTH];
    logic [23:0] rd_data_reg;

    logic [3:0] st_reg;
    logic [KSW-1:0] rem_reg;
    logic [7:0] q_reg;          // quotient, ks/60 < 69
    logic [RW-1:0] r_reg;
    logic signed [CW-1:0] dy_reg, dx_reg, hw_reg, cx_reg, cy_reg;
    logic [SQW:0] n_reg;
    logic [RW:0] a_reg;
    logic [XW-1:0] w_reg;
    logic [YW-1:0] h_reg;

    // pipeline: issue -> data -> gray -> compare
    logic v1_reg, v2_reg;
    logic [23:0] px3_reg;
    logic [17:0] gsum_reg;
    logic [23:0] pmax_reg, pmin_reg;
    logic [7:0] gmax_reg, gmin_reg;
    logic found_reg;
    logic [AW-1:0] addr;

    logic signed [CW-1:0] xx, yy;
    logic in_img;
    logic [7:0] gv;
    logic [9:0] wmin;
    logic [8:0] hmin;

    assign wmin = (32'(width_in) < MAX_WIDTH) ? 10'(width_in) : 10'(MAX_WIDTH);
    assign hmin = (32'(height_in) < MAX_HEIGHT) ? 9'(height_in) : 9'(MAX_HEIGHT);

    assign xx = cx_reg + dx_reg;
    assign yy = cy_reg + dy_reg;
    assign in_img = (xx >= 0) && (yy >= 0) && (xx < $signed({4'd0, w_reg}))
                    && (yy < $signed({5'd0, h_reg}));
    assign addr = AW'(32'(yy) * MAX_WIDTH + 32'(xx));
    // gray = sum/1000 via reciprocal: floor(s*67109/2^26) exact for s<=255000
    assign gv = 8'((36'(gsum_reg) * 36'd67109) >> 26);

    assign pop = (st_reg == S_IDLE) && avail;
    assign done = st_reg == S_DONE;
    assign bright = found_reg ? pmax_reg : 24'd0;
    assign dark = found_reg ? pmin_reg : 24'd0;
    assign found = found_reg;

    always_ff @(posedge clk)
    begin
        if (pop && cmd.mode == MODE_WRITE && 32'(cmd.x) < MAX_WIDTH && 32'(cmd.y) < MAX_HEIGHT)
            mem[AW'(32'(cmd.y) * MAX_WIDTH + 32'(cmd.x))] <= cmd.pix;
        rd_data_reg <= mem[addr];
        gsum_reg <= 18'd114 * 18'(rd_data_reg[7:0]) + 18'd587 * 18'(rd_data_reg[15:8])
                    + 18'd299 * 18'(rd_data_reg[23:16]);
        px3_reg <= rd_data_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            st_reg <= S_IDLE;
            v1_reg <= 1'b0; v2_reg <= 1'b0;
            found_reg <= 1'b0;
        end
        else
        begin
            v1_reg <= (st_reg == S_PIX) && in_img;
            v2_reg <= v1_reg;
            if (v2_reg)
            begin
                if (!found_reg || gv > gmax_reg)
                begin
                    gmax_reg <= gv; pmax_reg <= px3_reg;
                end
                if (!found_reg || gv < gmin_reg)
                begin
                    gmin_reg <= gv; pmin_reg <= px3_reg;
                end
                found_reg <= 1'b1;
            end
            case (st_reg)
                S_IDLE:
                    if (pop && cmd.mode != MODE_WRITE)
                    begin
                        rem_reg <= cmd.ks;
                        q_reg <= 8'd0;
                        cx_reg <= CW'(cmd.x);
                        cy_reg <= CW'(cmd.y);
                        w_reg <= wmin;
                        h_reg <= hmin;
                        found_reg <= 1'b0;
                        st_reg <= S_DIV;
                    end
                S_DIV:
                    if (rem_reg >= KSW'(60))
                    begin
                        rem_reg <= rem_reg - KSW'(60);
                        q_reg <= q_reg + 8'd1;
                    end
                    else
                    begin
                        logic [7:0] qq;
                        qq = q_reg + ((rem_reg > KSW'(30) || (rem_reg == KSW'(30) && q_reg[0]))
                                      ? 8'd1 : 8'd0);
                        r_reg <= (32'(qq) > MAX_RADIUS) ? RW'(MAX_RADIUS) : RW'(qq);
                        dy_reg <= -CW'((32'(qq) > MAX_RADIUS) ? MAX_RADIUS : 32'(qq));
                        st_reg <= S_ROW;
                    end
                S_ROW:
                begin
                    n_reg <= (SQW+1)'(32'(r_reg) * 32'(r_reg) - 32'(dy_reg) * 32'(dy_reg));
                    a_reg <= '0;
                    st_reg <= S_SQRT;
                end
                S_SQRT:
                    if ((32'(a_reg) + 1) * (32'(a_reg) + 1) <= 32'(n_reg))
                        a_reg <= a_reg + 1'b1;
                    else
                        st_reg <= S_RND;
                S_RND:
                begin
                    logic [RW:0] hv;
                    hv = (32'(n_reg) - 32'(a_reg) * 32'(a_reg) > 32'(a_reg)) ? a_reg + 1'b1 : a_reg;
                    hw_reg <= CW'(hv);
                    dx_reg <= -CW'(hv);
                    st_reg <= S_PIX;
                end
                S_PIX:
                    if (dx_reg == hw_reg)
                    begin
                        if (dy_reg == CW'(r_reg))
                            st_reg <= S_DRAIN1;
                        else
                        begin
                            dy_reg <= dy_reg + 1'b1;
                            st_reg <= S_ROW;
                        end
                    end
                    else
                        dx_reg <= dx_reg + 1'b1;
                S_DRAIN1: st_reg <= S_DRAIN2;
                S_DRAIN2: st_reg <= S_DRAIN3;
                S_DRAIN3: st_reg <= S_DONE;
                S_DONE:   st_reg <= S_IDLE;
                default:  st_reg <= S_IDLE;
            endcase
        end
    end
endmodule
`default_nettype wire

>>> hw/rtl/circular_window_extreme_color.sv
// Circular window extreme colour finder. Words are taken one at a time; busy while the
// two-word queue is full. Pixel write: stored when the idle back end pops it. Query:
// scans the 2R+1 disc rows, one frame read a cycle within a row; the row half-width is
// sqrt(R*R-dy*dy) rounded to nearest. Result strobe lasts one cycle; receiver cannot
// stall. Reset idles control and sets the size registers to 640x480; frame memory
// content is undefined until written.
`default_nettype none
module circular_window_extreme_color #(
    parameter int MAX_WIDTH  = cwec_pkg::DEF_MAX_WIDTH,
    parameter int MAX_HEIGHT = cwec_pkg::DEF_MAX_HEIGHT,
    parameter int MAX_RADIUS = cwec_pkg::DEF_MAX_RADIUS
) (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        start,
    output logic             busy,
    input  wire logic        mode,
    input  wire logic [9:0]  pixel_x,
    input  wire logic [8:0]  pixel_y,
    input  wire logic [7:0]  blue,
    input  wire logic [7:0]  green,
    input  wire logic [7:0]  red,
    input  wire logic [9:0]  center_x,
    input  wire logic [8:0]  center_y,
    input  wire logic [11:0] key_size,
    input  wire logic        cfg_we,
    input  wire logic        cfg_index,
    input  wire logic [9:0]  cfg_data,
    output logic             result_valid,
    output logic [7:0]       bright_blue,
    output logic [7:0]       bright_green,
    output logic [7:0]       bright_red,
    output logic [7:0]       dark_blue,
    output logic [7:0]       dark_green,
    output logic [7:0]       dark_red,
    output logic             any_inside
);
    import cwec_pkg::*;
    logic [XW-1:0] width_reg;
    logic [YW-1:0] height_reg;
    cmd_t in_cmd, head;
    logic avail, pop, full, found;
    logic [23:0] br, dk;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            width_reg <= RST_WIDTH;
            height_reg <= RST_HEIGHT;
        end
        else if (cfg_we)
        begin
            if (cfg_index == CFG_WIDTH)
                width_reg <= cfg_data;
            else
                height_reg <= cfg_data[YW-1:0];
        end
    end

    always_comb
    begin
        in_cmd.mode = mode;
        in_cmd.x = (mode == MODE_WRITE) ? pixel_x : center_x;
        in_cmd.y = (mode == MODE_WRITE) ? pixel_y : center_y;
        in_cmd.pix = {red, green, blue};
        in_cmd.ks = key_size;
    end

    assign busy = full;

    cwec_front u_front (
        .clk(clk), .rst_n(rst_n), .push(start && !full), .push_cmd(in_cmd),
        .full(full), .pop(pop), .avail(avail), .head(head)
    );

    cwec_back #(.MAX_WIDTH(MAX_WIDTH), .MAX_HEIGHT(MAX_HEIGHT), .MAX_RADIUS(MAX_RADIUS)) u_back (
        .clk(clk), .rst_n(rst_n), .avail(avail), .cmd(head), .pop(pop),
        .width_in(width_reg), .height_in(height_reg), .done(result_valid),
        .bright(br), .dark(dk), .found(found)
    );

    assign bright_blue = br[7:0];
    assign bright_green = br[15:8];
    assign bright_red = br[23:16];
    assign dark_blue = dk[7:0];
    assign dark_green = dk[15:8];
    assign dark_red = dk[23:16];
    assign any_inside = found;
endmodule
`default_nettype wire

>>> hw/rtl/cwec_checker.sv
// Port-level checks for the circular window extreme colour block.
// Bound to circular_window_extreme_color.
`default_nettype none
module cwec_checker (
    input wire logic clk,
    input wire logic rst_n,
    input wire logic result_valid,
    input wire logic any_inside,
    input wire logic [7:0] bright_blue,
    input wire logic [7:0] dark_red
);
    a_strobe: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid |=> !result_valid) else $error("strobe longer than one cycle");
    a_empty_b: assert property (@(posedge clk) disable iff (!rst_n)
        (result_valid && !any_inside) |-> bright_blue == 8'd0) else $error("empty not zero");
    a_empty_d: assert property (@(posedge clk) disable iff (!rst_n)
        (result_valid && !any_inside) |-> dark_red == 8'd0) else $error("empty not zero");
endmodule

bind circular_window_extreme_color cwec_checker u_chk (
    .clk(clk), .rst_n(rst_n), .result_valid(result_valid), .any_inside(any_inside),
    .bright_blue(bright_blue), .dark_red(dark_red)
);
`default_nettype wire

>>> bench/tb_circular_window_extreme_color.sv
// Testbench for circular_window_extreme_color: pixel writes, keypoint queries,
// image size registers. Depends on cwec_pkg and the block under test.
`timescale 1ns / 100ps

module tb_circular_window_extreme_color;
    import cwec_pkg::*;

    localparam int FW = DEF_MAX_WIDTH;
    localparam int FH = DEF_MAX_HEIGHT;

    typedef struct packed {
        logic [7:0] bb, bg, br, db, dg, dr;
        logic       any_in;
    } extremes_t;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        start = 1'b0;
    logic        busy;
    logic        mode = MODE_WRITE;
    logic [9:0]  pixel_x = '0;
    logic [8:0]  pixel_y = '0;
    logic [7:0]  blue = '0, green = '0, red = '0;
    logic [9:0]  center_x = '0;
    logic [8:0]  center_y = '0;
    logic [11:0] key_size = '0;
    logic        cfg_we = 1'b0;
    logic        cfg_index = CFG_WIDTH;
    logic [9:0]  cfg_data = '0;
    logic        result_valid;
    extremes_t   got;

    logic [23:0] frame_mem [0:FW*FH-1];
    bit          written [0:FW*FH-1];
    int          width_reg = 640;
    int          height_reg = 480;
    extremes_t   expected_q [$];
    int          errors = 0;
    int          idle_pct = 0;

    circular_window_extreme_color u_top (
        .clk(clk), .rst_n(rst_n), .start(start), .busy(busy), .mode(mode),
        .pixel_x(pixel_x), .pixel_y(pixel_y), .blue(blue), .green(green), .red(red),
        .center_x(center_x), .center_y(center_y), .key_size(key_size),
        .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
        .result_valid(result_valid),
        .bright_blue(got.bb), .bright_green(got.bg), .bright_red(got.br),
        .dark_blue(got.db), .dark_green(got.dg), .dark_red(got.dr),
        .any_inside(got.any_in)
    );

    always #5 clk = ~clk;

    function automatic int radius_of(int ks);
        int q;
        int rm;
        q = ks / 60;
        rm = ks % 60;
        if (2 * rm > 60 || (2 * rm == 60 && q % 2 == 1))
            q++;
        if (q > DEF_MAX_RADIUS)
            q = DEF_MAX_RADIUS;
        return q;
    endfunction

    function automatic int half_width(int n);
        int a;
        a = 0;
        while ((a + 1) * (a + 1) <= n)
            a++;
        if (n - a * a > a)
            a++;
        return a;
    endfunction

    function automatic int gray_of(logic [23:0] p);
        return (114 * int'(p[7:0]) + 587 * int'(p[15:8]) + 299 * int'(p[23:16])) / 1000;
    endfunction

    function automatic bit in_image(int x, int y);
        int w;
        int h;
        w = width_reg < FW ? width_reg : FW;
        h = height_reg < FH ? height_reg : FH;
        return x >= 0 && x < w && y >= 0 && y < h;
    endfunction

    // row-major scan, first brightest and first darkest win on ties
    function automatic extremes_t disc_extremes(int cx, int cy, int ks);
        extremes_t e;
        int r;
        int hw;
        int gv;
        int gmax;
        int gmin;
        bit found;
        logic [23:0] p;
        logic [23:0] pmax;
        logic [23:0] pmin;
        r = radius_of(ks);
        found = 0;
        gmax = 0;
        gmin = 0;
        pmax = '0;
        pmin = '0;
        for (int dy = -r; dy <= r; dy++) begin
            hw = half_width(r * r - dy * dy);
            for (int dx = -hw; dx <= hw; dx++) begin
                if (in_image(cx + dx, cy + dy)) begin
                    p = frame_mem[(cy + dy) * FW + cx + dx];
                    gv = gray_of(p);
                    if (!found || gv > gmax) begin
                        gmax = gv;
                        pmax = p;
                    end
                    if (!found || gv < gmin) begin
                        gmin = gv;
                        pmin = p;
                    end
                    found = 1;
                end
            end
        end
        e = '{pmax[7:0], pmax[15:8], pmax[23:16], pmin[7:0], pmin[15:8], pmin[23:16], found};
        return e;
    endfunction

    // one word through the start/busy handshake; leaves start high unless idling
    task automatic send_word(bit m, int px, int py, logic [23:0] col, int cx, int cy, int ks);
        mode <= m;
        pixel_x <= px[9:0];
        pixel_y <= py[8:0];
        blue <= col[7:0];
        green <= col[15:8];
        red <= col[23:16];
        center_x <= cx[9:0];
        center_y <= cy[8:0];
        key_size <= ks[11:0];
        start <= 1'b1;
        forever begin
            @(negedge clk);
            if (!busy)
                break;
        end
        @(posedge clk);
        if (m == MODE_WRITE) begin
            if (px < FW && py < FH) begin
                frame_mem[py * FW + px] = col;
                written[py * FW + px] = 1'b1;
            end
        end else begin
            expected_q.push_back(disc_extremes(cx, cy, ks));
        end
        if ($urandom_range(0, 99) < idle_pct) begin
            start <= 1'b0;
            repeat ($urandom_range(1, 6)) @(posedge clk);
        end
    endtask

    task automatic send_pixel(int px, int py, logic [23:0] col);
        send_word(MODE_WRITE, px, py, col, $urandom_range(0, 1023), $urandom_range(0, 511),
                  $urandom_range(0, 4095));
    endtask

    // write every unwritten in-image pixel of the disc first, then query
    task automatic send_query(int cx, int cy, int ks);
        int r;
        int hw;
        r = radius_of(ks);
        for (int dy = -r; dy <= r; dy++) begin
            hw = half_width(r * r - dy * dy);
            for (int dx = -hw; dx <= hw; dx++)
                if (in_image(cx + dx, cy + dy) && !written[(cy + dy) * FW + cx + dx])
                    send_pixel(cx + dx, cy + dy, $urandom);
        end
        send_word(1'b1, $urandom_range(0, 1023), $urandom_range(0, 511), $urandom,
                  cx, cy, ks);
    endtask

    task automatic settle();
        start <= 1'b0;
        @(posedge clk);
        while (expected_q.size() != 0)
            @(posedge clk);
        repeat (20) @(posedge clk);
        while (busy)
            @(posedge clk);
    endtask

    task automatic write_reg(logic idx, int value);
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_data <= value[9:0];
        @(posedge clk);
        cfg_we <= 1'b0;
        if (idx == CFG_WIDTH)
            width_reg = value;
        else
            height_reg = value;
        @(posedge clk);
    endtask

    task automatic test_corners_and_range();
        write_reg(CFG_WIDTH, 640);
        write_reg(CFG_HEIGHT, 480);
        send_pixel(0, 0, 24'hFFFFFF);
        send_pixel(639, 0, 24'h000000);
        send_pixel(0, 479, 24'hFF00FF);
        send_pixel(639, 479, 24'h00FF00);
        send_pixel(1023, 511, 24'h123456);   // out of range, ignored
        send_pixel(640, 0, 24'h654321);
        send_pixel(0, 480, 24'hABCDEF);
        send_query(0, 0, 0);
        send_query(639, 479, 4095);
        send_query(639, 0, 1919);
        settle();
    endtask

    task automatic test_rounding_and_ties();
        // equal grey across a small disc: every pixel ties, and the first scanned wins both ways
        for (int y = 200; y <= 206; y++)
            for (int x = 300; x <= 306; x++)
                send_pixel(x, y, 24'h808080);
        send_query(303, 203, 30);    // half rounds to even: radius 0
        send_query(303, 203, 90);    // half rounds to even: radius 2
        send_query(303, 203, 89);
        send_query(303, 203, 149);
        send_query(303, 203, 150);
        settle();
    endtask

    task automatic test_image_size();
        write_reg(CFG_WIDTH, 0);
        send_query(10, 10, 300);     // empty image: zeros
        settle();
        write_reg(CFG_WIDTH, 1);
        write_reg(CFG_HEIGHT, 1);
        send_query(0, 0, 600);
        send_query(5, 5, 60);        // disc misses the one pixel
        settle();
        write_reg(CFG_HEIGHT, 0);
        send_query(0, 0, 600);
        settle();
        write_reg(CFG_WIDTH, 1023);
        write_reg(CFG_HEIGHT, 511);
        send_query(630, 470, 700);
        settle();
    endtask

    task automatic test_random(int n, int pct);
        int cx;
        int cy;
        int ks;
        int sel;
        idle_pct = pct;
        for (int i = 0; i < n; i++) begin
            if ($urandom_range(0, 99) < 65) begin
                if ($urandom_range(0, 9) == 0)
                    send_pixel($urandom_range(0, 1023), $urandom_range(0, 511), $urandom);
                else
                    send_pixel($urandom_range(0, 79), $urandom_range(0, 59), $urandom);
            end else begin
                if ($urandom_range(0, 9) == 0) begin
                    cx = $urandom_range(0, 639);
                    cy = $urandom_range(0, 479);
                end else begin
                    cx = $urandom_range(0, 79);
                    cy = $urandom_range(0, 59);
                end
                sel = $urandom_range(0, 99);
                if (sel < 85)
                    ks = $urandom_range(0, 420);
                else if (sel < 96)
                    ks = $urandom_range(421, 1200);
                else
                    ks = $urandom_range(1201, 4095);
                send_query(cx, cy, ks);
            end
        end
        settle();
    endtask

    task automatic check_field(string name, int exp_v, int act_v);
        if (exp_v != act_v) begin
            $display("%0t %s mismatch: expected %0d actual %0d", $time, name, exp_v, act_v);
            errors++;
        end
    endtask

    always @(negedge clk) begin
        extremes_t e;
        if (rst_n && result_valid) begin
            if (expected_q.size() == 0) begin
                $display("%0t unexpected result: expected none actual %h", $time, got);
                errors++;
            end else begin
                e = expected_q.pop_front();
                check_field("bright_blue", e.bb, got.bb);
                check_field("bright_green", e.bg, got.bg);
                check_field("bright_red", e.br, got.br);
                check_field("dark_blue", e.db, got.db);
                check_field("dark_green", e.dg, got.dg);
                check_field("dark_red", e.dr, got.dr);
                check_field("any_inside", e.any_in, got.any_in);
            end
        end
    end

    initial begin
        #80ms;
        $display("tb_circular_window_extreme_color: FAIL");
        $finish;
    end

    initial begin
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_corners_and_range();
        test_rounding_and_ties();
        test_image_size();
        write_reg(CFG_WIDTH, 640);
        write_reg(CFG_HEIGHT, 480);
        test_random(135, 8);
        write_reg(CFG_WIDTH, 50);
        write_reg(CFG_HEIGHT, 40);
        test_random(135, 56);
        write_reg(CFG_WIDTH, 1023);
        write_reg(CFG_HEIGHT, 511);
        test_random(135, 0);
        settle();
        repeat (50) @(posedge clk);
        if (errors == 0)
            $display("tb_circular_window_extreme_color: PASS");
        else
            $display("tb_circular_window_extreme_color: FAIL");
        $finish;
    end
endmodule
